@@ src/kmer_window_minimizer_top_macros.svh @@
// assertion macros shared by the minimizer checker
// used by kwm_checker.sv through a plain include
`ifndef KMER_WINDOW_MINIMIZER_TOP_MACROS_SVH
`define KMER_WINDOW_MINIMIZER_TOP_MACROS_SVH

// clocked assertion, quiet while reset is applied
`define KWM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion that also holds while reset is applied
`define KWM_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/kwm_pkg.sv @@
// types, codes and constants of the k-mer window minimizer
// no dependencies
`default_nettype none

package kwm_pkg;

  // input kind codes
  localparam logic [1:0] KIND_BASE = 2'd0;
  localparam logic [1:0] KIND_EOL  = 2'd1;
  localparam logic [1:0] KIND_FILE = 2'd2;

  // base characters with a nonzero code
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_G = 8'h47;

  // configuration register indexes
  localparam logic REG_KMER_LEN = 1'b0;
  localparam logic REG_WIN_LEN  = 1'b1;

  // register reset values and the largest k
  localparam logic [5:0] KMER_LEN_RST = 6'd15;
  localparam logic [7:0] WIN_LEN_RST  = 8'd10;
  localparam logic [5:0] KMER_MAX     = 6'd32;

  localparam int unsigned KMER_W  = 64;
  localparam int unsigned BASE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned QDEPTH  = 2;

  // operation handed from front to back
  typedef enum logic [1:0] {
    OP_NONE,
    OP_BASE,
    OP_EOL,
    OP_FILE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] code;
  } qitem_t;

  // effective configuration seen by the back end
  typedef struct packed {
    logic [5:0]        k;
    logic [7:0]        w;
    logic [KMER_W-1:0] kmask;
  } cfg_t;

  // 2-bit base code, unknown characters map to zero
  function automatic logic [1:0] base_code(input logic [7:0] ch);
    logic [1:0] c;
    case (ch)
      CHAR_C:  c = 2'd1;
      CHAR_T:  c = 2'd2;
      CHAR_G:  c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ src/kmer_window_minimizer_top.sv @@
// k-mer window minimizer, top level: configuration registers and channel wiring
// depends on kwm_pkg, kwm_front, kwm_fifo, kwm_back
//
// Input channel (s_axis): one item per base, line end or new-file marker.
// tuser carries the kind (base, end of line, new file), tdata the ASCII base.
// Output channel (m_axis): one item per finished window of window_length
// k-mer starts, holding the smallest packed k-mer and its global address.
// Configuration: cfg_we_i writes kmer_length (index 0) or window_length
// (index 1) at the clock edge; write only while no items are in flight.
// Throughput: one item per cycle unless the output stalls. The front end decodes
// and queues items in a two-entry queue; the back end retires one item per cycle
// unless stalled, limited by its shift, 64-bit compare and address subtract.
// An accepted base passes through the queue; a finished window is registered.
// When m_axis_tready is low the result stays registered, the back end halts
// and the queue fills, after which s_axis_tready drops.
// Reset: all line, window and address state clears, registers return to
// k = 15 and w = 10; no clearing pass is needed.
`default_nettype none

module kmer_window_minimizer_top #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write port
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [kwm_pkg::CFG_W-1:0]   cfg_data_i,
  // input items
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [kwm_pkg::BASE_W-1:0]  s_axis_tdata,  // base
  input  wire logic [kwm_pkg::KIND_W-1:0]  s_axis_tuser,  // kind
  // result items
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // minimizer, address, zero pad
  output logic [((64 + ADDRESS_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  import kwm_pkg::*;

  localparam int unsigned OUT_W = ((64 + ADDRESS_BITS + 7) / 8) * 8;

  logic [5:0]        klen_q;
  logic [7:0]        wlen_q;
  cfg_t              cfg;
  logic [5:0]        k_eff;
  logic              push, pop, q_empty, q_full;
  qitem_t            push_item, pop_item;
  logic [KMER_W-1:0] out_min;
  logic [ADDRESS_BITS-1:0] out_addr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= KMER_LEN_RST;
      wlen_q <= WIN_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_KMER_LEN) begin
        klen_q <= cfg_data_i[5:0];
      end
      if (cfg_idx_i == REG_WIN_LEN) begin
        wlen_q <= cfg_data_i;
      end
    end
  end

  // clamp k to 1..32, w to at least 1, and build the k-mer mask
  always_comb begin
    if (klen_q == '0) begin
      k_eff = 6'd1;
    end else if (klen_q > KMER_MAX) begin
      k_eff = KMER_MAX;
    end else begin
      k_eff = klen_q;
    end
    cfg.k = k_eff;
    cfg.w = (wlen_q == '0) ? 8'd1 : wlen_q;
    for (int i = 0; i < KMER_W; i++) begin
      cfg.kmask[i] = (i < 2 * int'(k_eff));
    end
  end

  kwm_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_item_o   (push_item)
  );

  kwm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  kwm_back #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_min_o   (out_min),
    .out_addr_o  (out_addr)
  );

  assign m_axis_tdata = OUT_W'({out_addr, out_min});

endmodule

`default_nettype wire

@@ src/kwm_front.sv @@
// front end: accepts input items, decodes kind and base code
// depends on kwm_pkg
`default_nettype none

module kwm_front (
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [kwm_pkg::BASE_W-1:0]  s_axis_tdata,
  input  wire logic [kwm_pkg::KIND_W-1:0]  s_axis_tuser,
  input  wire logic                        q_full_i,
  output logic                             push_o,
  output kwm_pkg::qitem_t                  push_item_o
);
  import kwm_pkg::*;

  logic accept;

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && !q_full_i;

  // classify the item; unknown kinds are taken and dropped
  always_comb begin
    push_item_o.code = base_code(s_axis_tdata);
    case (s_axis_tuser)
      KIND_BASE: push_item_o.op = OP_BASE;
      KIND_EOL:  push_item_o.op = OP_EOL;
      KIND_FILE: push_item_o.op = OP_FILE;
      default:   push_item_o.op = OP_NONE;
    endcase
  end

  assign push_o = accept && (push_item_o.op != OP_NONE);

endmodule

`default_nettype wire

@@ src/kwm_fifo.sv @@
// small queue between front and back end
// depends on kwm_pkg
`default_nettype none

module kwm_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  kwm_pkg::qitem_t       push_item_i,
  input  wire logic             pop_i,
  output kwm_pkg::qitem_t       pop_item_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import kwm_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  qitem_t        mem_q [QDEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign empty_o    = (cnt_q == '0);
  assign full_o     = (cnt_q == CW'(QDEPTH));
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_item_o = mem_q[rptr_q];

  // pointer and fill count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ src/kwm_back.sv @@
// back end: k-mer shift, window tracking, minimum search and result register
// depends on kwm_pkg
`default_nettype none

module kwm_back #(
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  kwm_pkg::cfg_t                 cfg_i,
  input  wire logic                     q_empty_i,
  input  kwm_pkg::qitem_t               q_item_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [kwm_pkg::KMER_W-1:0]    out_min_o,
  output logic [ADDRESS_BITS-1:0]       out_addr_o
);
  import kwm_pkg::*;

  localparam int unsigned A = ADDRESS_BITS;

  logic [KMER_W-1:0] kmer_q, kmer_d, best_q, best_d;
  logic [A-1:0]      lpos_q, lpos_d, gpos_q, gpos_d, baddr_q, baddr_d;
  logic [7:0]        slot_q, slot_d;
  logic              ovalid_q, ovalid_d;
  logic [KMER_W-1:0] omin_q, omin_d;
  logic [A-1:0]      oaddr_q, oaddr_d;

  logic              lpos_sat, full, emit;
  logic [A-1:0]      lpos_new, gpos_new, k_ext, start_addr;
  logic [KMER_W-1:0] kmer_new, cand_best;
  logic [A-1:0]      cand_addr;

  // the back end advances when the result register is free or being taken
  assign q_pop_o = !q_empty_i && (!ovalid_q || out_ready_i);

  // per-base datapath
  assign lpos_sat   = &lpos_q;
  assign lpos_new   = lpos_sat ? lpos_q : lpos_q + 1'b1;
  assign gpos_new   = lpos_sat ? gpos_q : gpos_q + 1'b1;
  assign k_ext      = A'(cfg_i.k);
  assign full       = (lpos_new >= k_ext);
  assign start_addr = gpos_new - k_ext;
  assign kmer_new   = {kmer_q[KMER_W-3:0], q_item_i.code} & cfg_i.kmask;
  assign emit       = full && (slot_q >= cfg_i.w);
  assign cand_best  = emit ? '1 : best_q;
  assign cand_addr  = emit ? '0 : baddr_q;

  always_comb begin
    kmer_d   = kmer_q;
    lpos_d   = lpos_q;
    gpos_d   = gpos_q;
    slot_d   = slot_q;
    best_d   = best_q;
    baddr_d  = baddr_q;
    ovalid_d = ovalid_q && !out_ready_i;
    omin_d   = omin_q;
    oaddr_d  = oaddr_q;
    if (q_pop_o) begin
      case (q_item_i.op)
        OP_BASE: begin
          kmer_d = kmer_new;
          lpos_d = lpos_new;
          gpos_d = gpos_new;
          if (full) begin
            if (emit) begin
              ovalid_d = 1'b1;
              omin_d   = best_q;
              oaddr_d  = baddr_q;
            end
            if (kmer_new < cand_best) begin
              best_d  = kmer_new;
              baddr_d = start_addr;
            end else begin
              best_d  = cand_best;
              baddr_d = cand_addr;
            end
            slot_d = emit ? 8'd1 : slot_q + 8'd1;
          end
        end
        OP_EOL, OP_FILE: begin
          // line state cleared; global position kept unless a new file starts
          kmer_d  = '0;
          lpos_d  = '0;
          slot_d  = '0;
          best_d  = '1;
          baddr_d = '0;
          if (q_item_i.op == OP_FILE) begin
            gpos_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_q   <= '0;
      lpos_q   <= '0;
      gpos_q   <= '0;
      slot_q   <= '0;
      best_q   <= '1;
      baddr_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      kmer_q   <= kmer_d;
      lpos_q   <= lpos_d;
      gpos_q   <= gpos_d;
      slot_q   <= slot_d;
      best_q   <= best_d;
      baddr_q  <= baddr_d;
      ovalid_q <= ovalid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    omin_q  <= omin_d;
    oaddr_q <= oaddr_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_min_o   = omin_q;
  assign out_addr_o  = oaddr_q;

endmodule

`default_nettype wire

@@ src/kwm_checker.sv @@
// port-level checks for the k-mer window minimizer, bound to the top level
// depends on kmer_window_minimizer_top_macros.svh and kmer_window_minimizer_top
`default_nettype none

`include "kmer_window_minimizer_top_macros.svh"

module kwm_checker #(
  parameter int unsigned OUT_W = 112
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tready,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  logic out_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a held result keeps its payload
  `KWM_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed")

  // input back-pressure only follows a stalled output
  `KWM_ASSERT(a_bp_origin, !s_axis_tready |-> $past(out_stall), "stray input stall")

  // no result while reset is applied
  `KWM_ASSERT_RST(a_reset_quiet, !rst_ni |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind kmer_window_minimizer_top kwm_checker #(
  .OUT_W (OUT_W)
) u_kwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ verif/kmer_window_minimizer_top_tb.sv @@
// testbench for kmer_window_minimizer_top: stream driver, result monitor, in-line predictor
// depends on kwm_pkg and the kmer_window_minimizer_top rtl
module kmer_window_minimizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kwm_pkg::*;

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned OUT_W  = ((64 + ADDR_W + 7) / 8) * 8;

  // kind code the block must ignore
  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam logic [7:0] CHAR_A     = 8'h41;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] base;
  } stream_sym_t;

  typedef struct packed {
    logic [63:0]       minimizer;
    logic [ADDR_W-1:0] address;
  } window_min_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // base
  logic [1:0]       s_axis_tuser;   // kind
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;   // minimizer, address, zero pad

  kmer_window_minimizer_top #(
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // predictor state and register copies
  logic [5:0]        kmer_len_reg;
  logic [7:0]        win_len_reg;
  logic [63:0]       kmer_bits;
  logic [ADDR_W-1:0] line_pos;
  logic [ADDR_W-1:0] line_base;
  logic [7:0]        win_fill;
  logic [63:0]       win_best;
  logic [ADDR_W-1:0] win_best_addr;

  window_min_t window_mins_q[$];
  stream_sym_t sym_q[$];
  stream_sym_t cur_sym;
  window_min_t want;

  int unsigned syms_queued;
  int unsigned syms_taken;
  int unsigned mismatches;
  int unsigned src_wait;
  int unsigned sink_wait;
  int unsigned hold_left;
  bit          src_took;
  bit          src_idle;
  bit          sink_idle;

  // clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // run limit
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic void clear_line_state();
    kmer_bits     = '0;
    line_pos      = '0;
    win_fill      = '0;
    win_best      = '1;
    win_best_addr = '0;
  endfunction

  // advance the minimizer state by one accepted item, queue a finished window
  function automatic void advance_minimizer(logic [1:0] kind, logic [7:0] ch);
    int unsigned       k;
    int unsigned       w;
    logic [63:0]       kmask;
    logic [1:0]        code;
    logic [ADDR_W-1:0] start;
    window_min_t       done;
    case (kind)
      KIND_FILE: begin
        line_base = '0;
        clear_line_state();
      end
      KIND_EOL: begin
        line_base = line_base + line_pos;
        clear_line_state();
      end
      KIND_BASE: begin
        k = (kmer_len_reg == 0) ? 1 : (kmer_len_reg > 32) ? 32 : kmer_len_reg;
        w = (win_len_reg == 0) ? 1 : win_len_reg;
        kmask = (k == 32) ? '1 : ((64'd1 << (2 * k)) - 64'd1);
        case (ch)
          CHAR_C:  code = 2'd1;
          CHAR_T:  code = 2'd2;
          CHAR_G:  code = 2'd3;
          default: code = 2'd0;
        endcase
        kmer_bits = ((kmer_bits << 2) | 64'(code)) & kmask;
        if (line_pos != '1) line_pos = line_pos + 1'b1;
        if (line_pos < k) return;
        start = line_pos - ADDR_W'(k);
        // window full: emit it before taking the new k-mer
        if (win_fill >= w) begin
          done.minimizer = win_best;
          done.address   = win_best_addr;
          window_mins_q.insert(window_mins_q.size(), done);
          win_best      = '1;
          win_best_addr = '0;
          win_fill      = '0;
        end
        if (kmer_bits < win_best) begin
          win_best      = kmer_bits;
          win_best_addr = start + line_base;
        end
        win_fill = win_fill + 1'b1;
      end
      default: ;
    endcase
  endfunction

  // gap length: mostly none, some short, a few long
  function automatic int unsigned next_gap(bit enable);
    int unsigned r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] pick_base(bit g_heavy);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (g_heavy && r < 85) return CHAR_G;
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0:       return CHAR_A;
        1:       return CHAR_C;
        2:       return CHAR_T;
        default: return CHAR_G;
      endcase
    end
    if (r < 90) return 8'($urandom);
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  task automatic push_sym(logic [1:0] kind, logic [7:0] base);
    stream_sym_t sym;
    sym.kind = kind;
    sym.base = base;
    sym_q.insert(sym_q.size(), sym);
    syms_queued++;
  endtask

  // one line of bases with the odd ignored item mixed in
  task automatic queue_line(int unsigned n, bit g_heavy, bit close);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) push_sym(KIND_SPARE, 8'($urandom));
      push_sym(KIND_BASE, pick_base(g_heavy));
    end
    if (close) push_sym(KIND_EOL, 8'($urandom));
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_KMER_LEN) kmer_len_reg = val[5:0];
    else win_len_reg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // all items taken, all windows seen, then let the back end settle
  task automatic wait_drained();
    while (syms_taken != syms_queued || window_mins_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic run_phase(logic [7:0] k_raw, logic [7:0] w_raw, int unsigned budget,
                           bit g_heavy, bit s_idle, bit r_idle, int unsigned hold);
    int unsigned k;
    int unsigned w;
    int unsigned span;
    int unsigned first;
    int unsigned r;
    int unsigned n;
    int unsigned left;
    bit          line_close;
    wait_drained();
    write_reg(REG_KMER_LEN, k_raw);
    write_reg(REG_WIN_LEN, w_raw);
    k = (k_raw[5:0] == 0) ? 1 : (k_raw[5:0] > 32) ? 32 : k_raw[5:0];
    w = (w_raw == 0) ? 1 : w_raw;
    span      = k + w;
    src_idle  = s_idle;
    sink_idle = r_idle;
    hold_left = hold;
    first     = syms_queued;
    // all-G line: at k of 32 every k-mer is all ones
    if (g_heavy) begin
      for (int i = 0; i < 40; i++) push_sym(KIND_BASE, CHAR_G);
      push_sym(KIND_EOL, 8'h00);
    end
    while (syms_queued - first < budget) begin
      left = budget - (syms_queued - first);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        if ($urandom_range(0, 99) < 70) begin
          n          = $urandom_range(span, 3 * span);
          line_close = ($urandom_range(0, 9) != 0);
        end else begin
          n          = $urandom_range(0, span);
          line_close = 1'b1;
        end
        // keep the phase near its item budget
        if (n > left) n = left;
        queue_line(n, g_heavy, line_close);
      end else if (r < 90) begin
        push_sym(KIND_SPARE, 8'($urandom));
      end else if (r < 95) begin
        push_sym(KIND_FILE, 8'($urandom));
      end else begin
        push_sym(KIND_EOL, 8'($urandom));
      end
    end
    wait_drained();
  endtask

  // sender: items change at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || src_took)) begin
      src_took = 1'b0;
      if (src_wait != 0) begin
        src_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (sym_q.size() != 0) begin
        cur_sym = sym_q.pop_front();
        s_axis_tuser  <= cur_sym.kind;
        s_axis_tdata  <= cur_sym.base;
        s_axis_tvalid <= 1'b1;
        src_wait = next_gap(src_idle);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready with random stalls and the long hold-off
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_wait = next_gap(sink_idle);
    end
  end

  // hold-off counter
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left--;
  end

  // accepted items feed the predictor, results are checked in order
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      advance_minimizer(s_axis_tuser, s_axis_tdata);
      syms_taken++;
      src_took = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (window_mins_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected window result %h", m_axis_tdata);
      end else begin
        want = window_mins_q.pop_front();
        if (m_axis_tdata[63:0] !== want.minimizer ||
            m_axis_tdata[64 +: ADDR_W] !== want.address) begin
          mismatches++;
          if (mismatches <= 10)
            $display("window mismatch: minimizer exp %h got %h, address exp %h got %h",
                     want.minimizer, m_axis_tdata[63:0], want.address,
                     m_axis_tdata[64 +: ADDR_W]);
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    stream_sym_t directed[$];
    directed = '{
      '{KIND_FILE, 8'h00}, '{KIND_BASE, CHAR_A}, '{KIND_BASE, CHAR_C}, '{KIND_BASE, CHAR_T},
      '{KIND_BASE, CHAR_G}, '{KIND_BASE, 8'h00}, '{KIND_BASE, 8'hFF}, '{KIND_BASE, 8'h67},
      '{KIND_SPARE, CHAR_C}, '{KIND_BASE, CHAR_T}, '{KIND_EOL, 8'h00}, '{KIND_EOL, 8'hFF},
      '{KIND_BASE, CHAR_G}, '{KIND_BASE, CHAR_C}, '{KIND_BASE, CHAR_A}, '{KIND_FILE, 8'h5A},
      '{KIND_BASE, CHAR_T}, '{KIND_BASE, CHAR_T}, '{KIND_SPARE, 8'hFF}, '{KIND_BASE, CHAR_C},
      '{KIND_EOL, 8'hA5}
    };
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KMER_LEN;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = KIND_BASE;
    m_axis_tready = 1'b0;
    src_took      = 1'b0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    src_wait      = 0;
    sink_wait     = 0;
    hold_left     = 0;
    syms_queued   = 0;
    syms_taken    = 0;
    mismatches    = 0;
    kmer_len_reg  = KMER_LEN_RST;
    win_len_reg   = WIN_LEN_RST;
    line_base     = '0;
    clear_line_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values of the registers: one line past k + w
    queue_line(30, 1'b0, 1'b1);
    wait_drained();

    // smallest k and w: every base after the first of a line closes a window
    write_reg(REG_KMER_LEN, 8'h01);
    write_reg(REG_WIN_LEN, 8'h01);
    foreach (directed[i]) push_sym(directed[i].kind, directed[i].base);

    // random phases over the register extremes
    run_phase(8'hFF, 8'h00, 80, 1'b1, 1'b0, 1'b0, 0);
    run_phase(8'h20, 8'hFF, 450, 1'b0, 1'b1, 1'b1, 0);
    run_phase(8'h01, 8'h01, 80, 1'b0, 1'b0, 1'b0, 400);
    run_phase(8'hE0, 8'h02, 80, 1'b1, 1'b1, 1'b1, 0);
    run_phase(8'h40, 8'h03, 80, 1'b0, 1'b1, 1'b0, 0);
    repeat (4) run_phase(8'($urandom), 8'($urandom_range(1, 12)), 80, 1'b0, 1'b1, 1'b1, 0);

    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && window_mins_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/kwm_pkg.sv
src/kwm_front.sv
src/kwm_fifo.sv
src/kwm_back.sv
src/kmer_window_minimizer_top.sv
src/kwm_checker.sv
verif/kmer_window_minimizer_top_tb.sv
